// ===== sv/ddru_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// ddru_pkg: shared types and constants for the dense shortest-path block
// Operation codes, sequencer states, read kinds and the request bundle of
// the shared compare unit.
// ---------------------------------------------------------------------------
package ddru_pkg;

	localparam int DIST_W = 31;
	localparam int VTX_W  = 4;
	localparam int CNT_W  = 5;

	localparam logic [DIST_W-1:0] INF_DIST = 31'h7FFF_FFFF;
	localparam logic [CNT_W-1:0]  VCOUNT_RESET = 5'd16;

	typedef enum logic [1:0] {
		OP_WRITE = 2'd0,
		OP_RUN   = 2'd1,
		OP_READ  = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_READ,
		S_SEL,
		S_SEL_DRAIN,
		S_MARK,
		S_RELAX,
		S_RELAX_DRAIN,
		S_EMIT
	} state_t;

	typedef enum logic [2:0] {
		RK_SEL,
		RK_DIST,
		RK_W,
		RK_OUT,
		RK_READ
	} rd_kind_t;

	typedef struct packed {
		logic              relax;
		logic              picked;
		logic [DIST_W-1:0] data;
		logic [DIST_W-1:0] best;
		logic [DIST_W-1:0] cur;
	} cmp_req_t;

endpackage
`default_nettype wire

// ===== sv/ddru_cmp_unit.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// ddru_cmp_unit: shared add and compare unit
// In selection mode it tests whether a candidate distance is at most the
// best so far. In relaxation mode it forms the path sum through the picked
// vertex and tests whether it improves the current distance.
// ---------------------------------------------------------------------------
module ddru_cmp_unit (
	input  wire ddru_pkg::cmp_req_t                 req,
	output logic                                    take,
	output logic [ddru_pkg::DIST_W-1:0]             sum
);
	import ddru_pkg::*;

	logic [DIST_W:0] add_w;
	logic [DIST_W:0] lhs;
	logic [DIST_W:0] rhs;
	logic            less;
	logic            equal;
	logic            allowed;

	always_comb begin
		add_w   = {1'b0, req.best} + {1'b0, (req.relax ? req.data : {DIST_W{1'b0}})};
		lhs     = req.relax ? add_w : {1'b0, req.data};
		rhs     = req.relax ? {1'b0, req.cur} : add_w;
		less    = lhs < rhs;
		equal   = lhs == rhs;
		allowed = !req.picked;
		if (req.relax) begin
			allowed = allowed && (req.data != '0) && (req.best != INF_DIST);
		end
		take = allowed && (less || (!req.relax && equal));
		sum  = add_w[DIST_W-1:0];
	end

endmodule
`default_nettype wire

// ===== sv/dense_dijkstra_row_update_top.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// dense_dijkstra_row_update_top: adjacency matrix with in-place shortest paths
// A weight write is done in the accepting cycle, and busy stays low. A read keeps
// busy high for one cycle, and its result reaches the ports through the matrix
// read register and the output registers. A run with n vertices keeps busy high
// through n-1 rounds of selection and relaxation, paced by one matrix access per
// cycle. Its n results follow one per cycle, and the last passes through the same
// registers after the final busy cycle. Results cannot be stalled. Reset clears the
// sequencer and the picked flags and sets vertex_count to 16. The matrix holds
// undefined values until written.
// ---------------------------------------------------------------------------
module dense_dijkstra_row_update_top #(
	parameter int MAX_VERTICES = 16
) (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               start,
	output logic                              busy,
	input  wire  [1:0]                        op,
	input  wire  [3:0]                        row,
	input  wire  [3:0]                        col,
	input  wire  [ddru_pkg::DIST_W-1:0]       weight,
	output logic                              strobe,
	output logic [ddru_pkg::VTX_W-1:0]        vertex,
	output logic [ddru_pkg::DIST_W-1:0]       distance,
	output logic                              last,
	input  wire                               cfg_valid,
	output logic                              cfg_ready,
	input  wire  [ddru_pkg::CNT_W-1:0]        cfg_data
);
	import ddru_pkg::*;

	localparam int VB    = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
	localparam int AW    = 2 * VB;
	localparam int DEPTH = MAX_VERTICES << VB;
	localparam int CW    = $clog2(MAX_VERTICES + 1);
	localparam int CMPW  = (CW > CNT_W) ? CW : CNT_W;

	logic [DIST_W-1:0] mem [0:DEPTH-1];

	state_t            state_q;
	state_t            state_d;
	logic [CNT_W-1:0]  vcount_q;
	logic [CW-1:0]     n_c;
	logic [CW-1:0]     n_m1;
	logic [CW-1:0]     n_m2;
	logic              row_ok;
	logic              col_ok;
	logic              accept;

	logic [VB-1:0]     src_q;
	logic [VB-1:0]     row_q;
	logic [VB-1:0]     m_q;
	logic [VTX_W-1:0]  col_q;
	logic              rd_zero_q;
	logic [VB-1:0]     idx_q;
	logic [VB-1:0]     round_q;
	logic              ph_q;
	logic [MAX_VERTICES-1:0] picked_q;
	logic [DIST_W-1:0] best_q;
	logic [DIST_W-1:0] distv_q;
	logic              idx_last;
	logic              round_last;

	logic              iss_vld;
	rd_kind_t          iss_kind;
	logic [AW-1:0]     iss_addr;
	logic [VTX_W-1:0]  iss_vertex;
	logic              iss_last;
	logic              idx_inc;
	logic              idx_clr;
	logic              ph_flip;
	logic              mark;
	logic              round_inc;
	logic              run_init;
	logic              sel_init;
	logic              read_go;

	logic              vld_s1;
	rd_kind_t          kind_s1;
	logic [VTX_W-1:0]  vertex_s1;
	logic              last_s1;
	logic [VB-1:0]     idx_s1;
	logic [DIST_W-1:0] rdata_s1;

	cmp_req_t          cmp_req;
	logic              cmp_take;
	logic [DIST_W-1:0] cmp_sum;
	logic              w_take;
	logic              sel_take;
	logic              host_we;
	logic              mem_we;
	logic [AW-1:0]     mem_waddr;
	logic [DIST_W-1:0] mem_wdata;

	logic              strobe_q;
	logic [VTX_W-1:0]  vertex_q;
	logic [DIST_W-1:0] distance_q;
	logic              last_q;

	always_comb begin
		if (CMPW'(vcount_q) < CMPW'(2)) begin
			n_c = CW'(2);
		end else if (CMPW'(vcount_q) > CMPW'(MAX_VERTICES)) begin
			n_c = CW'(MAX_VERTICES);
		end else begin
			n_c = CW'(vcount_q);
		end
		n_m1       = n_c - CW'(1);
		n_m2       = n_c - CW'(2);
		row_ok     = CMPW'(row) < CMPW'(n_c);
		col_ok     = CMPW'(col) < CMPW'(n_c);
		idx_last   = CW'(idx_q) == n_m1;
		round_last = CW'(round_q) == n_m2;
	end

	assign accept    = start && (state_q == S_IDLE);
	assign busy      = state_q != S_IDLE;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		iss_vld    = 1'b0;
		iss_kind   = RK_SEL;
		iss_addr   = {src_q, idx_q};
		iss_vertex = VTX_W'(idx_q);
		iss_last   = 1'b0;
		idx_inc    = 1'b0;
		idx_clr    = 1'b0;
		ph_flip    = 1'b0;
		mark       = 1'b0;
		round_inc  = 1'b0;
		run_init   = 1'b0;
		sel_init   = 1'b0;
		read_go    = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					unique case (op_t'(op))
						OP_RUN: begin
							if (row_ok) begin
								run_init = 1'b1;
								sel_init = 1'b1;
								state_d  = S_SEL;
							end
						end
						OP_READ: begin
							read_go = 1'b1;
							state_d = S_READ;
						end
						OP_WRITE, OP_NONE: begin
							state_d = S_IDLE;
						end
						default: begin
							state_d = S_IDLE;
						end
					endcase
				end
			end
			S_READ: begin
				iss_vld    = 1'b1;
				iss_kind   = RK_READ;
				iss_addr   = {row_q, VB'(col_q)};
				iss_vertex = col_q;
				iss_last   = 1'b1;
				state_d    = S_IDLE;
			end
			S_SEL: begin
				iss_vld  = 1'b1;
				iss_kind = RK_SEL;
				if (idx_last) begin
					idx_clr = 1'b1;
					state_d = S_SEL_DRAIN;
				end else begin
					idx_inc = 1'b1;
				end
			end
			S_SEL_DRAIN: begin
				state_d = S_MARK;
			end
			S_MARK: begin
				mark    = 1'b1;
				state_d = S_RELAX;
			end
			S_RELAX: begin
				iss_vld  = 1'b1;
				ph_flip  = 1'b1;
				iss_kind = ph_q ? RK_W : RK_DIST;
				iss_addr = ph_q ? {m_q, idx_q} : {src_q, idx_q};
				if (ph_q) begin
					if (idx_last) begin
						idx_clr = 1'b1;
						state_d = S_RELAX_DRAIN;
					end else begin
						idx_inc = 1'b1;
					end
				end
			end
			S_RELAX_DRAIN: begin
				if (round_last) begin
					state_d = S_EMIT;
				end else begin
					round_inc = 1'b1;
					sel_init  = 1'b1;
					state_d   = S_SEL;
				end
			end
			S_EMIT: begin
				iss_vld  = 1'b1;
				iss_kind = RK_OUT;
				iss_last = idx_last;
				if (idx_last) begin
					idx_clr = 1'b1;
					state_d = S_IDLE;
				end else begin
					idx_inc = 1'b1;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcount_q <= VCOUNT_RESET;
			idx_q    <= '0;
			round_q  <= '0;
			ph_q     <= 1'b0;
			picked_q <= '0;
			vld_s1   <= 1'b0;
			strobe_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				vcount_q <= cfg_data;
			end
			if (run_init || idx_clr) begin
				idx_q <= '0;
			end else if (idx_inc) begin
				idx_q <= idx_q + VB'(1);
			end
			if (run_init) begin
				round_q <= '0;
				ph_q    <= 1'b0;
			end else begin
				if (round_inc) begin
					round_q <= round_q + VB'(1);
				end
				if (ph_flip) begin
					ph_q <= !ph_q;
				end
			end
			if (run_init) begin
				picked_q <= '0;
			end else if (mark) begin
				picked_q[m_q] <= 1'b1;
			end
			vld_s1   <= iss_vld;
			strobe_q <= vld_s1 && ((kind_s1 == RK_OUT) || (kind_s1 == RK_READ));
		end
	end

	always_ff @(posedge clk) begin
		kind_s1   <= iss_kind;
		vertex_s1 <= iss_vertex;
		last_s1   <= iss_last;
		idx_s1    <= idx_q;
		if (run_init) begin
			src_q <= VB'(row);
		end
		if (read_go) begin
			row_q     <= VB'(row);
			col_q     <= col;
			rd_zero_q <= !(row_ok && col_ok);
		end
		if (sel_init) begin
			best_q <= INF_DIST;
			m_q    <= '0;
		end else if (sel_take) begin
			best_q <= rdata_s1;
			m_q    <= idx_s1;
		end
		if (vld_s1 && (kind_s1 == RK_DIST)) begin
			distv_q <= rdata_s1;
		end
		vertex_q   <= vertex_s1;
		last_q     <= last_s1;
		distance_q <= ((kind_s1 == RK_READ) && rd_zero_q) ? '0 : rdata_s1;
	end

	always_comb begin
		cmp_req.relax  = kind_s1 == RK_W;
		cmp_req.picked = picked_q[idx_s1];
		cmp_req.data   = rdata_s1;
		cmp_req.best   = best_q;
		cmp_req.cur    = distv_q;
	end

	ddru_cmp_unit u_cmp (
		.req  (cmp_req),
		.take (cmp_take),
		.sum  (cmp_sum)
	);

	always_comb begin
		sel_take  = vld_s1 && (kind_s1 == RK_SEL) && cmp_take;
		w_take    = vld_s1 && (kind_s1 == RK_W) && cmp_take;
		host_we   = accept && (op_t'(op) == OP_WRITE) && row_ok && col_ok;
		mem_we    = host_we || w_take;
		mem_waddr = w_take ? {src_q, idx_s1} : {VB'(row), VB'(col)};
		mem_wdata = w_take ? cmp_sum : weight;
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rdata_s1 <= mem[iss_addr];
	end

	assign strobe   = strobe_q;
	assign vertex   = vertex_q;
	assign distance = distance_q;
	assign last     = last_q;

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
// ---------------------------------------------------------------------------
// testbench: self-checking bench for the dense shortest-path matrix block
// Fills the whole matrix, then sends writes, reads, shortest-path runs and
// unused operations under several vertex counts. An internal copy of the
// matrix predicts every result item, and each item from the block is
// compared field by field with the oldest prediction.
// ---------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import ddru_pkg::*;

	localparam int MAX_VERTICES = 16;
	localparam int CYCLE_LIMIT  = 1_500_000;

	typedef struct {
		op_t               op;
		logic [3:0]        row;
		logic [3:0]        col;
		logic [DIST_W-1:0] weight;
	} matrix_op_t;

	typedef struct {
		logic [VTX_W-1:0]  vertex;
		logic [DIST_W-1:0] distance;
		logic              last;
	} row_entry_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	logic              busy;
	logic [1:0]        op = OP_NONE;
	logic [3:0]        row = '0;
	logic [3:0]        col = '0;
	logic [DIST_W-1:0] weight = '0;
	logic              strobe;
	logic [VTX_W-1:0]  vertex;
	logic [DIST_W-1:0] distance;
	logic              last;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [CNT_W-1:0]  cfg_data = '0;

	logic [DIST_W-1:0] adj [MAX_VERTICES][MAX_VERTICES];
	logic [CNT_W-1:0]  vertex_count_q = VCOUNT_RESET;
	matrix_op_t        pending_ops [$];
	row_entry_t        expected_entries [$];
	bit                item_taken = 1'b0;
	int unsigned       gap_left = 0;
	int unsigned       fail_count = 0;
	int unsigned       cycle_count = 0;

	dense_dijkstra_row_update_top #(
		.MAX_VERTICES(MAX_VERTICES)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.op(op),
		.row(row),
		.col(col),
		.weight(weight),
		.strobe(strobe),
		.vertex(vertex),
		.distance(distance),
		.last(last),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	function automatic int unsigned vertices_in_use();
		int unsigned n;
		n = vertex_count_q;
		if (n < 2) n = 2;
		if (n > MAX_VERTICES) n = MAX_VERTICES;
		return n;
	endfunction

	task automatic apply_matrix_op(input matrix_op_t it);
		int unsigned n;
		int unsigned m;
		logic [MAX_VERTICES-1:0] picked;
		logic [DIST_W-1:0] best;
		longint unsigned sum;
		row_entry_t entry;
		n = vertices_in_use();
		case (it.op)
			OP_WRITE: begin
				if (it.row < n && it.col < n) adj[it.row][it.col] = it.weight;
			end
			OP_READ: begin
				entry.vertex = it.col;
				entry.distance = (it.row < n && it.col < n) ? adj[it.row][it.col] : '0;
				entry.last = 1'b1;
				expected_entries.push_back(entry);
			end
			OP_RUN: begin
				if (it.row < n) begin
					picked = '0;
					for (int unsigned r = 0; r + 1 < n; r++) begin
						best = INF_DIST;
						m = 0;
						for (int unsigned v = 0; v < n; v++) begin
							if (!picked[v] && adj[it.row][v] <= best) begin
								best = adj[it.row][v];
								m = v;
							end
						end
						picked[m] = 1'b1;
						for (int unsigned v = 0; v < n; v++) begin
							if (!picked[v] && adj[m][v] != 0 && adj[it.row][m] != INF_DIST) begin
								sum = longint'(adj[it.row][m]) + longint'(adj[m][v]);
								if (sum < longint'(adj[it.row][v])) adj[it.row][v] = sum[DIST_W-1:0];
							end
						end
					end
					for (int unsigned v = 0; v < n; v++) begin
						entry.vertex = v;
						entry.distance = adj[it.row][v];
						entry.last = (v + 1 == n);
						expected_entries.push_back(entry);
					end
				end
			end
			default: begin
			end
		endcase
	endtask

	function automatic int unsigned pick_gap();
		int unsigned sel;
		sel = $urandom_range(0, 99);
		if (sel < 60) return 0;
		if (sel < 90) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [DIST_W-1:0] pick_weight();
		int unsigned sel;
		sel = $urandom_range(0, 99);
		if (sel < 25) return '0;
		if (sel < 60) return DIST_W'($urandom_range(1, 100));
		if (sel < 80) return DIST_W'($urandom());
		if (sel < 90) return INF_DIST - DIST_W'($urandom_range(0, 100));
		return INF_DIST;
	endfunction

	task automatic queue_op(input op_t code, input int unsigned r, input int unsigned c,
			input logic [DIST_W-1:0] w);
		matrix_op_t it;
		it.op = code;
		it.row = r[3:0];
		it.col = c[3:0];
		it.weight = w;
		pending_ops.push_back(it);
	endtask

	task automatic queue_random(input int unsigned count);
		int unsigned n;
		int unsigned sel;
		int unsigned r;
		int unsigned c;
		op_t code;
		n = vertices_in_use();
		for (int unsigned i = 0; i < count; i++) begin
			sel = $urandom_range(0, 99);
			if (sel < 40) code = OP_WRITE;
			else if (sel < 70) code = OP_READ;
			else if (sel < 92) code = OP_RUN;
			else code = OP_NONE;
			r = ($urandom_range(0, 9) < 8) ? $urandom_range(0, n - 1) : $urandom_range(0, 15);
			c = ($urandom_range(0, 9) < 8) ? $urandom_range(0, n - 1) : $urandom_range(0, 15);
			queue_op(code, r, c, pick_weight());
		end
	endtask

	task automatic wait_idle();
		int unsigned quiet;
		quiet = 0;
		while (quiet < 20) begin
			@(posedge clk);
			if (pending_ops.size() == 0 && !start && !busy && expected_entries.size() == 0)
				quiet++;
			else
				quiet = 0;
		end
	endtask

	task automatic write_vertex_count(input logic [CNT_W-1:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		vertex_count_q = value;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	always @(posedge clk) begin : accept_items
		matrix_op_t it;
		if (arst_n && start && !busy) begin
			it.op = op_t'(op);
			it.row = row;
			it.col = col;
			it.weight = weight;
			apply_matrix_op(it);
			item_taken = 1'b1;
		end
	end

	always @(negedge clk) begin : drive_items
		logic next_start;
		matrix_op_t it;
		next_start = start;
		if (!arst_n) begin
			next_start = 1'b0;
		end else begin
			if (start && item_taken) begin
				next_start = 1'b0;
				item_taken = 1'b0;
			end
			if (!next_start) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (pending_ops.size() > 0) begin
					it = pending_ops.pop_front();
					op <= it.op;
					row <= it.row;
					col <= it.col;
					weight <= it.weight;
					next_start = 1'b1;
					gap_left = pick_gap();
				end
			end
		end
		start <= next_start;
	end

	always @(posedge clk) begin : check_results
		row_entry_t exp_entry;
		if (arst_n && strobe) begin
			if (expected_entries.size() == 0) begin
				$error("unexpected result item: vertex %0d, distance %0d, last %0d",
					vertex, distance, last);
				fail_count++;
			end else begin
				exp_entry = expected_entries.pop_front();
				if (vertex !== exp_entry.vertex) begin
					$error("vertex: expected %0d, got %0d", exp_entry.vertex, vertex);
					fail_count++;
				end
				if (distance !== exp_entry.distance) begin
					$error("distance: expected %0d, got %0d", exp_entry.distance, distance);
					fail_count++;
				end
				if (last !== exp_entry.last) begin
					$error("last: expected %0d, got %0d", exp_entry.last, last);
					fail_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		logic [CNT_W-1:0] counts [9];
		counts = '{5'd16, 5'd0, 5'd2, 5'd31, 5'd1, 5'd17, 5'd9, 5'd3, 5'd16};
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Every entry is written before anything reads the matrix.
		write_vertex_count(5'd16);
		for (int unsigned r = 0; r < MAX_VERTICES; r++)
			for (int unsigned c = 0; c < MAX_VERTICES; c++)
				queue_op(OP_WRITE, r, c, pick_weight());

		queue_op(OP_READ, 0, 0, '0);
		queue_op(OP_READ, 15, 15, '0);
		queue_op(OP_WRITE, 15, 0, INF_DIST);
		queue_op(OP_WRITE, 0, 15, '0);
		queue_op(OP_READ, 15, 0, '0);
		queue_op(OP_RUN, 15, 0, INF_DIST);
		queue_op(OP_RUN, 0, 15, '0);
		queue_op(OP_NONE, 15, 15, INF_DIST);
		wait_idle();

		write_vertex_count(5'd5);
		queue_op(OP_WRITE, 7, 1, 31'd9);
		queue_op(OP_WRITE, 1, 9, 31'd9);
		queue_op(OP_READ, 7, 2, '0);
		queue_op(OP_READ, 2, 9, '0);
		queue_op(OP_RUN, 10, 3, '0);
		queue_op(OP_NONE, 12, 0, '0);
		// Equal distances along the row, apart from its diagonal entry, exercise the tie break.
		for (int unsigned c = 0; c < 5; c++)
			if (c != 1) queue_op(OP_WRITE, 1, c, 31'd7);
		queue_op(OP_RUN, 1, 0, '0);
		// A path whose sum exceeds the 31-bit range must not wrap.
		queue_op(OP_WRITE, 3, 0, 31'd5);
		queue_op(OP_WRITE, 0, 4, INF_DIST - 1);
		queue_op(OP_WRITE, 3, 4, INF_DIST);
		queue_op(OP_RUN, 3, 0, '0);
		wait_idle();

		foreach (counts[i]) begin
			write_vertex_count(counts[i]);
			queue_random(22);
			wait_idle();
		end

		repeat (100) @(posedge clk);
		if (fail_count == 0 && expected_entries.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
